// ===== sv/fdhr_pkg.sv =====
// ----------------------------------------------------------------------------
// fdhr_pkg
// Types, register indexes and constants shared by the fan drive block.
// ----------------------------------------------------------------------------
package fdhr_pkg;

	localparam int TIME_BITS = 32;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int PCT_W = 7;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	localparam logic [PCT_W-1:0] RST_CLAMP_MIN = 7'd0;
	localparam logic [PCT_W-1:0] RST_CLAMP_MAX = 7'd100;
	localparam logic RST_FAN_MODE = 1'b0;
	localparam logic [15:0] RST_KICK_MS = 16'd750;
	localparam logic [PCT_W-1:0] RST_RAMP_STEP = 7'd3;
	localparam logic [PCT_W-1:0] RST_HYSTERESIS = 7'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLAMP_MIN = 3'd0,
		REG_CLAMP_MAX = 3'd1,
		REG_FAN_MODE = 3'd2,
		REG_KICK_MS = 3'd3,
		REG_RAMP_STEP = 3'd4,
		REG_HYSTERESIS = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		BS_IDLE = 3'd0,
		BS_BOOST = 3'd1,
		BS_RAMP = 3'd2,
		BS_HOLD = 3'd3,
		BS_EMBER = 3'd4
	} burn_t;

	typedef struct packed {
		logic [PCT_W-1:0] demand;
		logic [2:0] burn_state;
		logic no_fault;
		logic ember_latched;
		logic exhaust_fallback;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [PCT_W-1:0] fan_percent;
		logic fan_enabled;
	} out_item_t;

	typedef struct packed {
		logic [PCT_W-1:0] clamp_min;
		logic [PCT_W-1:0] clamp_max;
		logic fan_mode;
		logic [15:0] kick_ms;
		logic [PCT_W-1:0] ramp_step;
		logic [PCT_W-1:0] hysteresis;
	} cfg_t;

	typedef struct packed {
		logic fan_on;
		logic [PCT_W-1:0] last_pct;
		logic kick_armed;
		logic [TIME_BITS-1:0] kick_deadline;
		logic [2:0] prev_state;
	} fan_state_t;

endpackage

// ===== sv/fdhr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fdhr_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module fdhr_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fdhr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fdhr_pkg::CFG_DATA_W-1:0]  cfg_data,
	output fdhr_pkg::cfg_t                   cfg
);

	fdhr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clamp_min <= fdhr_pkg::RST_CLAMP_MIN;
			cfg_q.clamp_max <= fdhr_pkg::RST_CLAMP_MAX;
			cfg_q.fan_mode <= fdhr_pkg::RST_FAN_MODE;
			cfg_q.kick_ms <= fdhr_pkg::RST_KICK_MS;
			cfg_q.ramp_step <= fdhr_pkg::RST_RAMP_STEP;
			cfg_q.hysteresis <= fdhr_pkg::RST_HYSTERESIS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fdhr_pkg::REG_CLAMP_MIN: cfg_q.clamp_min <= cfg_data[6:0];
				fdhr_pkg::REG_CLAMP_MAX: cfg_q.clamp_max <= cfg_data[6:0];
				fdhr_pkg::REG_FAN_MODE: cfg_q.fan_mode <= cfg_data[0];
				fdhr_pkg::REG_KICK_MS: cfg_q.kick_ms <= cfg_data[15:0];
				fdhr_pkg::REG_RAMP_STEP: cfg_q.ramp_step <= cfg_data[6:0];
				fdhr_pkg::REG_HYSTERESIS: cfg_q.hysteresis <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/fdhr_tick_logic.sv =====
// ----------------------------------------------------------------------------
// fdhr_tick_logic
// One control tick: burn-state handling, rule chain, start kick and ramp.
// ----------------------------------------------------------------------------
module fdhr_tick_logic (
	input  fdhr_pkg::in_item_t    item,
	input  fdhr_pkg::cfg_t        cfg,
	input  fdhr_pkg::fan_state_t  cur,
	output fdhr_pkg::fan_state_t  nxt,
	output fdhr_pkg::out_item_t   res
);

	logic [2:0] st;
	logic [fdhr_pkg::TIME_BITS-1:0] now_t;
	logic [fdhr_pkg::TIME_BITS-1:0] kick_len;
	logic [fdhr_pkg::TIME_BITS-1:0] dl_eff;
	logic [fdhr_pkg::TIME_BITS-1:0] rem;
	logic kick_active;
	logic [6:0] tgt_lo;
	logic [6:0] tgt;
	logic signed [7:0] diff;
	logic signed [7:0] step_s;
	logic signed [7:0] d;
	logic [6:0] ramped;
	logic [7:0] on_level;
	logic fan_on;
	logic run;
	logic [6:0] pct;

	assign st = item.burn_state;
	assign now_t = item.now_ms[fdhr_pkg::TIME_BITS-1:0];
	assign kick_len = {{(fdhr_pkg::TIME_BITS-16){1'b0}}, cfg.kick_ms};

	// The deadline is armed on the first tick from rest; the kick runs while
	// the distance to it, taken modulo the timer width, is in 1..kick_ms.
	assign dl_eff = cur.kick_armed ? cur.kick_deadline : now_t + kick_len;
	assign rem = dl_eff - now_t;
	assign kick_active = (rem != '0) && (rem <= kick_len);

	// The max clamp is applied last, so it wins when min exceeds max.
	assign tgt_lo = (item.demand < cfg.clamp_min) ? cfg.clamp_min : item.demand;
	assign tgt = (tgt_lo > cfg.clamp_max) ? cfg.clamp_max : tgt_lo;
	assign diff = $signed({1'b0, tgt}) - $signed({1'b0, cur.last_pct});
	assign step_s = $signed({1'b0, cfg.ramp_step});

	always_comb begin
		if (diff > step_s) begin
			d = step_s;
		end else if (diff < -step_s) begin
			d = -step_s;
		end else begin
			d = diff;
		end
	end

	assign ramped = cur.last_pct + d[6:0];
	assign on_level = {1'b0, cfg.clamp_min} + {1'b0, cfg.hysteresis};

	always_comb begin
		nxt = cur;
		fan_on = cur.fan_on;
		pct = '0;
		run = 1'b0;

		if (st != cur.prev_state) begin
			if (cur.prev_state == fdhr_pkg::BS_HOLD && st == fdhr_pkg::BS_RAMP) begin
				fan_on = 1'b1;
			end
			if (st == fdhr_pkg::BS_BOOST || st == fdhr_pkg::BS_IDLE) begin
				fan_on = 1'b0;
			end
			nxt.prev_state = st;
		end

		if (item.exhaust_fallback && (st == fdhr_pkg::BS_BOOST ||
				st == fdhr_pkg::BS_RAMP || st == fdhr_pkg::BS_HOLD)) begin
			fan_on = 1'b1;
			nxt.last_pct = fdhr_pkg::PCT_FULL;
			nxt.kick_armed = 1'b0;
			pct = fdhr_pkg::PCT_FULL;
		end else if (!item.no_fault || item.ember_latched || st == fdhr_pkg::BS_EMBER) begin
			fan_on = 1'b0;
			nxt.last_pct = '0;
			nxt.kick_armed = 1'b0;
		end else if (st == fdhr_pkg::BS_BOOST) begin
			fan_on = 1'b1;
			pct = fdhr_pkg::PCT_FULL;
		end else if (cfg.fan_mode) begin
			fan_on = 1'b1;
			run = 1'b1;
		end else if (item.demand < cfg.clamp_min) begin
			fan_on = 1'b0;
			nxt.last_pct = '0;
			nxt.kick_armed = 1'b0;
		end else begin
			if ({1'b0, item.demand} >= on_level) begin
				fan_on = 1'b1;
			end
			if (!fan_on) begin
				nxt.last_pct = '0;
				nxt.kick_armed = 1'b0;
			end else begin
				run = 1'b1;
			end
		end

		if (run) begin
			if (cur.last_pct == '0 && kick_active) begin
				nxt.kick_armed = 1'b1;
				nxt.kick_deadline = dl_eff;
				pct = fdhr_pkg::PCT_FULL;
			end else begin
				nxt.kick_armed = 1'b0;
				nxt.last_pct = ramped;
				pct = ramped;
			end
		end

		nxt.fan_on = fan_on;
	end

	assign res.fan_percent = pct;
	assign res.fan_enabled = fan_on;

endmodule

// ===== sv/fan_drive_hysteresis_ramp.sv =====
// A beat is taken into the input register, passes through the tick logic and leaves from the result register.
// Throughput: one beat per cycle while the output is not stalled, set by the combinational tick logic and state update.
// A stalled output holds the pipe; the input register refills as the result is taken.
// Reset clears the pipeline valids, the fan state and loads the register defaults.
// No clearing pass is needed; the block accepts beats right after reset.
// ----------------------------------------------------------------------------
// fan_drive_hysteresis_ramp
// Fan drive with hysteresis, timed start kick and per-tick ramp limiter.
// ----------------------------------------------------------------------------
module fan_drive_hysteresis_ramp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  fdhr_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output fdhr_pkg::out_item_t              out_data,
	input  logic                             cfg_we,
	input  logic [fdhr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fdhr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	fdhr_pkg::cfg_t cfg;
	fdhr_pkg::in_item_t item_s1;
	logic valid_s1;
	fdhr_pkg::out_item_t res_s2;
	logic valid_s2;
	fdhr_pkg::fan_state_t state_q;
	fdhr_pkg::fan_state_t state_nxt;
	fdhr_pkg::out_item_t res_nxt;
	logic adv;

	fdhr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fdhr_tick_logic u_tick (
		.item (item_s1),
		.cfg  (cfg),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// The tick in stage one retires, and commits its state, when the result
	// register is free or being emptied in the same cycle.
	assign adv = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.fan_on <= 1'b0;
			state_q.last_pct <= '0;
			state_q.kick_armed <= 1'b0;
			state_q.kick_deadline <= '0;
			state_q.prev_state <= fdhr_pkg::BS_IDLE;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_data = res_s2;

	a_off_means_rest: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.fan_on |-> state_q.last_pct == '0)
		else $error("fan flag clear while last percent is nonzero");

	a_kick_from_rest: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.kick_armed |-> state_q.last_pct == '0)
		else $error("kick armed while the output is off rest");

	a_retire_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("retired tick did not reach the result register");

	a_free_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("empty input stage refused a beat");

endmodule
